// ===== rtl/core/isr_pkg.sv =====
// Package for the integer square root unit.
// Holds the control word that travels along the cell chain.
// No dependencies.
`timescale 1ns / 1ps

package isr_pkg;

  typedef struct packed {
    logic valid;
    logic neg;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/isr_cell.sv =====
// One cell of the square root chain: resolves one root bit per item.
// Takes two radicand bits, trial-subtracts, hands the result to the next cell.
// Depends on isr_pkg.
`timescale 1ns / 1ps

module isr_cell #(
  parameter int ROOT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  isr_pkg::cell_ctrl_t        ctrl_in,
  input  logic [ROOT_BITS+1:0]       rem_in,
  input  logic [ROOT_BITS-1:0]       root_in,
  input  logic [2*ROOT_BITS-1:0]     rad_in,
  output isr_pkg::cell_ctrl_t        ctrl_out,
  output logic [ROOT_BITS+1:0]       rem_out,
  output logic [ROOT_BITS-1:0]       root_out,
  output logic [2*ROOT_BITS-1:0]     rad_out
);

  localparam int REM_W = ROOT_BITS + 2;
  localparam int RAD_W = 2 * ROOT_BITS;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic [REM_W:0]   diff;
  logic             fits;

  assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
  assign trial  = {root_in, 2'b01};
  assign diff   = {1'b0, rem_sh} - {1'b0, trial};
  assign fits   = !diff[REM_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else if (advance) begin
      ctrl_out.valid <= ctrl_in.valid;
      ctrl_out.neg   <= ctrl_in.neg;
      rem_out        <= fits ? diff[REM_W-1:0] : rem_sh;
      root_out       <= {root_in[ROOT_BITS-2:0], fits};
      rad_out        <= {rad_in[RAD_W-3:0], 2'b00};
    end
  end

endmodule

// ===== rtl/core/integer_square_root_unit.sv =====
// Integer square root unit: floor square root of a signed operand, -1 if negative.
// A chain of isr_cell instances, one per root bit, feeds an output register.
// Depends on isr_pkg and isr_cell.
//
//   channel | handshake          | payload
//   --------+--------------------+----------------------------
//   input   | in_valid/in_ready  | operand (OPERAND_WIDTH, signed)
//   output  | out_valid/out_ready| root (OPERAND_WIDTH/2+1, signed)
//
// An item passes from accept through each cell of the chain in turn and
// then through the output register.
// One item is in the chain at a time; the next is taken once the last cell
// hands its result to the output register, so a new item enters while a
// finished result still waits. A stalled output holds the last cell.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps

module integer_square_root_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [OPERAND_WIDTH-1:0] operand,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [OPERAND_WIDTH/2:0] root
);

  localparam int ROOT_BITS = (OPERAND_WIDTH + 1) / 2;
  localparam int ROOT_W    = OPERAND_WIDTH / 2 + 1;
  localparam int REM_W     = ROOT_BITS + 2;
  localparam int RAD_W     = 2 * ROOT_BITS;

  isr_pkg::cell_ctrl_t        ctrl [ROOT_BITS+1];
  logic [REM_W-1:0]           rem  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0]       part [ROOT_BITS+1];
  logic [RAD_W-1:0]           rad  [ROOT_BITS+1];
  logic [ROOT_BITS:1]         valids;

  logic accept;
  logic advance;
  logic last_valid;
  logic busy;

  assign accept     = in_valid && in_ready;
  assign in_ready   = !busy;
  assign last_valid = ctrl[ROOT_BITS].valid;
  assign advance    = !(last_valid && out_valid && !out_ready);

  assign ctrl[0].valid = accept;
  assign ctrl[0].neg   = operand[OPERAND_WIDTH-1];
  assign rem[0]        = '0;
  assign part[0]       = '0;
  assign rad[0]        = RAD_W'(unsigned'(operand));

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_cell
    isr_cell #(
      .ROOT_BITS(ROOT_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .ctrl_in (ctrl[i]),
      .rem_in  (rem[i]),
      .root_in (part[i]),
      .rad_in  (rad[i]),
      .ctrl_out(ctrl[i+1]),
      .rem_out (rem[i+1]),
      .root_out(part[i+1]),
      .rad_out (rad[i+1])
    );
  end

  for (genvar i = 1; i <= ROOT_BITS; i++) begin : g_valids
    assign valids[i] = ctrl[i].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (last_valid && advance) begin
        busy <= 1'b0;
      end
      if (last_valid && advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last_valid && advance) begin
      root <= ctrl[ROOT_BITS].neg ? '1 : {1'b0, part[ROOT_BITS][ROOT_W-2:0]};
    end
  end

  a_one_in_chain: assert property (@(posedge clk) disable iff (rst)
    $countones(valids[ROOT_BITS:1]) <= 1)
    else $error("more than one item in the cell chain");

  a_idle_chain_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> valids[ROOT_BITS:1] == '0)
    else $error("cell chain holds an item while idle");

  a_reach_end: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##ROOT_BITS last_valid)
    else $error("item did not reach the last cell in time");

  a_busy_set: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not set after accept");

endmodule

// ===== verif/tb_integer_square_root_unit.sv =====
// Self-checking testbench for integer_square_root_unit: directed table, then random operands.
// Each root is held to its typed row's value or an in-bench bit-by-bit floor sqrt predictor.
// Depends on the integer_square_root_unit RTL only.
`timescale 1ns / 1ps

module tb_integer_square_root_unit;

  localparam int OPERAND_WIDTH  = 32;
  localparam int ROOT_WIDTH     = OPERAND_WIDTH / 2 + 1;
  localparam int NUM_DIRECTED   = 20;
  localparam int NUM_RANDOM     = 1250;
  localparam int NUM_TOTAL      = NUM_DIRECTED + NUM_RANDOM;
  localparam int QUIET_ITEMS    = 150;
  localparam int STALL_AT_ROOT  = 300;
  localparam int STALL_CYCLES   = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic signed [OPERAND_WIDTH-1:0] operand_t;
  typedef logic signed [ROOT_WIDTH-1:0]    root_t;

  typedef struct {
    operand_t value;
    bit       typed;
    root_t    want;
  } sqrt_row_t;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  operand_t operand;
  logic     out_valid;
  logic     out_ready;
  root_t    root;

  root_t    pending_roots[$];
  bit       item_typed;
  root_t    item_want;
  bit       quiet_phase;
  bit       stall_done;
  int       in_count;
  int       out_count;
  int       errors;
  int       idle_cycles;
  int       hold_left;

  sqrt_row_t sqrt_rows [NUM_DIRECTED] = '{
    '{32'sd0,          1'b1, 17'sd0},
    '{32'sd1,          1'b1, 17'sd1},
    '{32'sd2,          1'b1, 17'sd1},
    '{32'sd3,          1'b1, 17'sd1},
    '{32'sd4,          1'b1, 17'sd2},
    '{32'sd24,         1'b0, 17'sd0},
    '{32'sd25,         1'b1, 17'sd5},
    '{32'sd26,         1'b0, 17'sd0},
    '{-32'sd1,         1'b1, -17'sd1},
    '{32'h80000000,    1'b1, -17'sd1},
    '{32'h7fffffff,    1'b1, 17'sd46340},
    '{32'sd2147395600, 1'b1, 17'sd46340},
    '{32'sd2147395599, 1'b1, 17'sd46339},
    '{32'sd1073741824, 1'b1, 17'sd32768},
    '{32'sd1073741823, 1'b1, 17'sd32767},
    '{32'h55555555,    1'b0, 17'sd0},
    '{32'haaaaaaaa,    1'b1, -17'sd1},
    '{32'h0000ffff,    1'b0, 17'sd0},
    '{32'sd65536,      1'b1, 17'sd256},
    '{32'h7ffffffe,    1'b0, 17'sd0}
  };

  integer_square_root_unit #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .operand  (operand),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .root     (root)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic root_t floor_sqrt(operand_t value);
    logic [63:0] acc;
    logic [63:0] trial;
    logic [63:0] target;
    if (value < 0) begin
      return '1;
    end
    acc    = '0;
    target = {{(64 - OPERAND_WIDTH){1'b0}}, value};
    for (int b = 31; b >= 0; b--) begin
      trial = acc | (64'd1 << b);
      if (trial * trial <= target) begin
        acc = trial;
      end
    end
    return acc[ROOT_WIDTH-1:0];
  endfunction

  function automatic operand_t random_operand();
    logic [63:0] sq;
    int          k;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick <= 2) begin
      return $urandom;
    end else if (pick <= 5) begin
      k  = $urandom_range(0, 46340);
      sq = k * k;
      sq = sq + $urandom_range(0, 2) - 1;
      if (sq > 64'h7fffffff && sq != 64'hffffffffffffffff) begin
        sq = 64'h7fffffff;
      end
      return sq[OPERAND_WIDTH-1:0];
    end else if (pick <= 7) begin
      return $urandom_range(0, 1023);
    end else if (pick == 8) begin
      return $urandom & 32'h7fffffff;
    end
    return $urandom | 32'h80000000;
  endfunction

  task automatic send_item(operand_t value, bit typed, root_t want);
    int gap;
    int target;
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      operand  <= $urandom;
      repeat (gap) @(negedge clk);
    end
    operand    <= value;
    item_typed <= typed;
    item_want  <= want;
    in_valid   <= 1'b1;
    target = in_count + 1;
    do @(negedge clk); while (in_count != target);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        pending_roots.push_back(item_typed ? item_want : floor_sqrt(operand));
        in_count++;
      end
      if (out_valid && out_ready) begin
        out_count++;
        if (pending_roots.size() == 0) begin
          errors++;
          $display("%0t: unexpected root, expected none, actual %0d", $realtime, root);
        end else begin
          if (root !== pending_roots[0]) begin
            errors++;
            $display("%0t: root mismatch, expected %0d, actual %0d",
                     $realtime, pending_roots[0], root);
          end
          void'(pending_roots.pop_front());
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    stall_done = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!stall_done && out_count >= STALL_AT_ROOT) begin
        stall_done = 1'b1;
        hold_left  = STALL_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        hold_left  = $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    operand     = '0;
    item_typed  = 1'b0;
    item_want   = '0;
    quiet_phase = 1'b0;
    in_count    = 0;
    out_count   = 0;
    errors      = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (sqrt_rows[i]) begin
      send_item(sqrt_rows[i].value, sqrt_rows[i].typed, sqrt_rows[i].want);
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (NUM_DIRECTED + i >= NUM_TOTAL - QUIET_ITEMS) begin
        quiet_phase = 1'b1;
      end
      send_item(random_operand(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
